// ----- design/crng_pkg.sv -----
// ----------------------------------------------------------------------------
// crng_pkg
// Shared types, constants and the modular fold for the combined shuffled RNG.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crng_pkg;

  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int FOLD_W = 8;

  localparam logic [VAL_W-1:0]  MOD_ONE       = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD_TWO       = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL_ONE       = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_TWO       = 16'd40692;
  // 2^31 mod m, used to fold the high part of the product back in
  localparam logic [FOLD_W-1:0] FOLD_ONE      = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_TWO      = 8'd249;
  localparam logic [VAL_W-1:0]  GEN_TWO_RESET = 31'd123456789;
  localparam logic [VAL_W-1:0]  SEED_RESET    = 31'd1234;
  localparam logic [VAL_W-1:0]  SEED_MAX      = 31'd2147483562;
  localparam logic [VAL_W-1:0]  OUT_SPAN      = 31'd2147483562;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_FOLD,
    ST_PREP,
    ST_FETCH,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic gen_load;
    logic step_one;
    logic step_two;
    logic mem_re;
    logic mem_we;
    logic wsel_init;
    logic last_ld_init;
    logic emit;
  } ctl_t;

  // mul*x mod m from the full product; result below m
  function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] prod,
                                                input logic [FOLD_W-1:0] k,
                                                input logic [VAL_W-1:0]  m);
    logic [MUL_W+FOLD_W-1:0] hi_k;
    logic [VAL_W:0]          sum;
    hi_k = (MUL_W+FOLD_W)'(prod[PROD_W-1:VAL_W]) * (MUL_W+FOLD_W)'(k);
    sum  = {1'b0, prod[VAL_W-1:0]} + (VAL_W+1)'(hi_k);
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/crng_mem.sv -----
// ----------------------------------------------------------------------------
// crng_mem
// Shuffle table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crng_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [crng_pkg::VAL_W-1:0] rdata,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [crng_pkg::VAL_W-1:0] wdata
);

  logic [crng_pkg::VAL_W-1:0] mem [DEPTH];
  logic [crng_pkg::VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/crng_gen.sv -----
// ----------------------------------------------------------------------------
// crng_gen
// The two congruential generators: product registers and modular fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crng_gen (
  input  logic                       clk,
  input  logic                       rst_n,
  input  crng_pkg::ctl_t             ctl,
  input  logic [crng_pkg::VAL_W-1:0] seed_val,
  output logic [crng_pkg::VAL_W-1:0] gen_one,
  output logic [crng_pkg::VAL_W-1:0] gen_two,
  output logic [crng_pkg::VAL_W-1:0] fold_one
);

  logic [crng_pkg::VAL_W-1:0]  gen_one_r, gen_one_nxt;
  logic [crng_pkg::VAL_W-1:0]  gen_two_r, gen_two_nxt;
  logic [crng_pkg::PROD_W-1:0] prod_one_r, prod_two_r;
  logic [crng_pkg::VAL_W-1:0]  fold_two;

  // products always track the current generator values
  always_ff @(posedge clk) begin
    prod_one_r <= crng_pkg::PROD_W'(gen_one_r) * crng_pkg::PROD_W'(crng_pkg::MUL_ONE);
    prod_two_r <= crng_pkg::PROD_W'(gen_two_r) * crng_pkg::PROD_W'(crng_pkg::MUL_TWO);
  end

  assign fold_one = crng_pkg::mod_fold(prod_one_r, crng_pkg::FOLD_ONE, crng_pkg::MOD_ONE);
  assign fold_two = crng_pkg::mod_fold(prod_two_r, crng_pkg::FOLD_TWO, crng_pkg::MOD_TWO);

  always_comb begin
    gen_one_nxt = gen_one_r;
    gen_two_nxt = gen_two_r;
    if (ctl.gen_load) begin
      gen_one_nxt = seed_val;
      gen_two_nxt = seed_val;
    end else begin
      if (ctl.step_one) begin
        gen_one_nxt = fold_one;
      end
      if (ctl.step_two) begin
        gen_two_nxt = fold_two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_one_r <= '0;
      gen_two_r <= crng_pkg::GEN_TWO_RESET;
    end else begin
      gen_one_r <= gen_one_nxt;
      gen_two_r <= gen_two_nxt;
    end
  end

  assign gen_one = gen_one_r;
  assign gen_two = gen_two_r;

endmodule

`default_nettype wire

// ----- design/crng_ctrl.sv -----
// ----------------------------------------------------------------------------
// crng_ctrl
// Sequencer for warm-up, table fetch and result write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crng_ctrl #(
  parameter int DEPTH  = 32,
  parameter int SLOT_W = 5,
  parameter int CNT_W  = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_reseed,
  input  logic              can_emit,
  output crng_pkg::ctl_t    ctl,
  output logic [SLOT_W-1:0] init_idx
);

  crng_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             needs_init_r, needs_init_nxt;
  logic             accept;
  logic             init_req;
  logic             cnt_zero;
  logic             cnt_in_table;

  assign accept       = in_valid && (state_r == crng_pkg::ST_IDLE);
  assign init_req     = in_reseed || needs_init_r;
  assign cnt_zero     = (cnt_r == '0);
  assign cnt_in_table = (cnt_r < CNT_W'(DEPTH));
  assign init_idx     = cnt_r[SLOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crng_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = init_req ? crng_pkg::ST_INIT_MUL : crng_pkg::ST_STEP;
        end
      end
      crng_pkg::ST_INIT_MUL:  state_nxt = crng_pkg::ST_INIT_FOLD;
      crng_pkg::ST_INIT_FOLD: begin
        state_nxt = cnt_zero ? crng_pkg::ST_PREP : crng_pkg::ST_INIT_MUL;
      end
      crng_pkg::ST_PREP:      state_nxt = crng_pkg::ST_FETCH;
      crng_pkg::ST_FETCH:     state_nxt = crng_pkg::ST_STEP;
      crng_pkg::ST_STEP: begin
        if (can_emit) begin
          state_nxt = crng_pkg::ST_IDLE;
        end
      end
      default:                state_nxt = crng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      crng_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (init_req) begin
            ctl.gen_load = 1'b1;
          end else begin
            ctl.mem_re   = 1'b1;
            ctl.step_one = 1'b1;
            ctl.step_two = 1'b1;
          end
        end
      end
      crng_pkg::ST_INIT_FOLD: begin
        ctl.step_one     = 1'b1;
        ctl.mem_we       = cnt_in_table;
        ctl.wsel_init    = 1'b1;
        ctl.last_ld_init = cnt_zero;
      end
      crng_pkg::ST_FETCH: begin
        ctl.mem_re   = 1'b1;
        ctl.step_one = 1'b1;
        ctl.step_two = 1'b1;
      end
      crng_pkg::ST_STEP: begin
        ctl.emit   = can_emit;
        ctl.mem_we = can_emit;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    needs_init_nxt = needs_init_r;
    if (ctl.gen_load) begin
      cnt_nxt = CNT_W'(DEPTH + 7);
    end else if (state_r == crng_pkg::ST_INIT_FOLD) begin
      if (cnt_zero) begin
        needs_init_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= crng_pkg::ST_IDLE;
      cnt_r        <= '0;
      needs_init_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      needs_init_r <= needs_init_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/combined_lcg_shuffle_rng_top.sv -----
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top
// Combined two-generator congruential RNG with a shuffle table.
// ----------------------------------------------------------------------------
// Each request on the in_ channel returns one value on the out_ channel, in
// the range 1 to 2147483562. in_reseed set on a request restarts the
// sequence from the seed register; the first request after reset does so too.
// The seed is written over the cfg_ channel (always ready) and is used only
// at the next restart; zero counts as one.
// A plain request: the accept cycle reads the shuffle table slot picked by
// the last value and folds both generators, then the step state forms the
// value and writes the slot back. The result register and out_valid are
// loaded at the end of the step state. The table read feeds the next slot
// choice, which bounds the rate. A restart adds the warm-up steps, then a
// prep state and a fetch state; every warm-up step is a multiply state and
// a fold state on the same generator.
// A new request is taken while a result still waits in the output register;
// if out_ready stays low the block holds its finished step and stops taking
// requests until the register drains. Reset clears the control state and
// loads the seed register with 1234; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_reseed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [crng_pkg::VAL_W-1:0] out_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [crng_pkg::VAL_W-1:0] cfg_seed
);

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
  localparam logic [63:0] SLOT_DIV = 64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH);

  crng_pkg::ctl_t             ctl;
  logic [SLOT_W-1:0]          init_idx;
  logic [SLOT_W-1:0]          slot;
  logic [SLOT_W-1:0]          slot_r;
  logic [crng_pkg::VAL_W-1:0] seed_r, seed_nxt;
  logic [crng_pkg::VAL_W-1:0] seed_val;
  logic [crng_pkg::VAL_W-1:0] last_r, last_nxt;
  logic [crng_pkg::VAL_W-1:0] out_value_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [crng_pkg::VAL_W-1:0] gen_one, gen_two, fold_one;
  logic [crng_pkg::VAL_W-1:0] rdata;
  logic [SLOT_W-1:0]          waddr;
  logic [crng_pkg::VAL_W-1:0] wdata;
  logic [crng_pkg::VAL_W:0]   diff;
  logic [crng_pkg::VAL_W:0]   y_wide;
  logic [crng_pkg::VAL_W-1:0] y;
  logic                       can_emit;

  assign cfg_ready = 1'b1;
  assign seed_nxt  = cfg_valid ? cfg_seed : seed_r;

  always_comb begin
    seed_val = seed_r;
    if (seed_r == '0) begin
      seed_val = crng_pkg::VAL_W'(1);
    end else if (seed_r > crng_pkg::SEED_MAX) begin
      seed_val = crng_pkg::SEED_MAX;
    end
  end

  // thresholds are elaboration constants, so this is a row of compares
  always_comb begin
    slot = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if (64'(last_r) >= 64'(k) * SLOT_DIV) begin
        slot = SLOT_W'(k);
      end
    end
  end

  assign can_emit = !out_valid_r || out_ready;

  crng_ctrl #(
    .DEPTH  (TABLE_DEPTH),
    .SLOT_W (SLOT_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_reseed (in_reseed),
    .can_emit  (can_emit),
    .ctl       (ctl),
    .init_idx  (init_idx)
  );

  crng_gen u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .seed_val (seed_val),
    .gen_one  (gen_one),
    .gen_two  (gen_two),
    .fold_one (fold_one)
  );

  // reads and writes fall in different states, so no forwarding is needed
  assign waddr = ctl.wsel_init ? init_idx : slot_r;
  assign wdata = ctl.wsel_init ? fold_one : gen_one;

  crng_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .re    (ctl.mem_re),
    .raddr (slot),
    .rdata (rdata),
    .we    (ctl.mem_we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // table entry minus second generator, wrapped into 1..span
  assign diff   = {1'b0, rdata} - {1'b0, gen_two};
  assign y_wide = (diff[crng_pkg::VAL_W] || (diff == '0))
                  ? diff + {1'b0, crng_pkg::OUT_SPAN} : diff;
  assign y      = y_wide[crng_pkg::VAL_W-1:0];

  always_comb begin
    last_nxt = last_r;
    if (ctl.emit) begin
      last_nxt = y;
    end else if (ctl.last_ld_init) begin
      last_nxt = fold_one;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_re) begin
      slot_r <= slot;
    end
    if (ctl.emit) begin
      out_value_r <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= crng_pkg::SEED_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value != '0) && (out_value <= crng_pkg::OUT_SPAN))
    else $error("result value out of range");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mem_re && ctl.mem_we))
    else $error("table read and write in the same cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrites a waiting result");

  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> $past(ctl.mem_re) || $past(ctl.emit == 1'b0 && !can_emit))
    else $error("result formed without a table read");

endmodule

`default_nettype wire
